[sv/lens_distortion_projection_top_defines.svh]
// Assertion macros for the lens projection block.
// Used by the port checker; depends on nothing.
`ifndef LENS_DISTORTION_PROJECTION_TOP_DEFINES_SVH
`define LENS_DISTORTION_PROJECTION_TOP_DEFINES_SVH

// property checked only while out of reset
`define LDP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define LDP_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ldp_pkg.sv]
// Shared widths, register indexes and clamp helpers for the lens projection block.
// No dependencies.
package ldp_pkg;

    localparam int FRAC = 28;   // fraction bits of normalized values
    localparam int WD   = 48;   // intermediate width
    localparam int WS   = 51;   // width of a sum of up to six intermediates
    localparam int WQ   = 32;   // width of points, quotients and pixels

    typedef enum logic [2:0] {
        REG_FOCAL_X = 3'd0,
        REG_FOCAL_Y = 3'd1,
        REG_PP      = 3'd2,
        REG_K1      = 3'd3,
        REG_K2      = 3'd4,
        REG_K3      = 3'd5,
        REG_P1      = 3'd6,
        REG_P2      = 3'd7
    } t_cfg_idx;

    // value with its sticky clamp flag
    typedef struct packed {
        logic                 sat;
        logic signed [WD-1:0] val;
    } t_qv;

    typedef struct packed {
        logic                 sat;
        logic signed [WQ-1:0] val;
    } t_q32;

    function automatic t_qv f_clamp48(input logic signed [WS-1:0] v);
        t_qv r;
        r.sat = !((&v[WS-1:WD-1]) || (~|v[WS-1:WD-1]));
        if (!r.sat) begin
            r.val = v[WD-1:0];
        end else if (v[WS-1]) begin
            r.val = {1'b1, {(WD-1){1'b0}}};
        end else begin
            r.val = {1'b0, {(WD-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic t_q32 f_clamp32(input logic signed [WS-1:0] v);
        t_q32 r;
        r.sat = !((&v[WS-1:WQ-1]) || (~|v[WS-1:WQ-1]));
        if (!r.sat) begin
            r.val = v[WQ-1:0];
        end else if (v[WS-1]) begin
            r.val = {1'b1, {(WQ-1){1'b0}}};
        end else begin
            r.val = {1'b0, {(WQ-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

[sv/ldp_delay.sv]
// Enabled shift line: a word passes through DEPTH registers, which shift only while i_en is high.
// No package dependency.
module ldp_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

[sv/ldp_mulq.sv]
// Pipelined Q.28 fractional multiply with magnitude truncation and 48-bit clamp.
// Depends on ldp_pkg. Registered steps: magnitudes, partial products (32x32 and smaller), shifted sum, clamp and sign.
module ldp_mulq (
    input  logic         i_clk,
    input  logic         i_en,
    input  ldp_pkg::t_qv i_a,
    input  ldp_pkg::t_qv i_b,
    output ldp_pkg::t_qv o_p
);
    import ldp_pkg::*;

    localparam int WR = 2*WD - FRAC;

    logic [WD-1:0]   r1_ua, r1_ub;
    logic            r1_neg, r1_sat;
    logic [63:0]     r2_p0;
    logic [47:0]     r2_p1, r2_p2;
    logic [31:0]     r2_p3;
    logic            r2_neg, r2_sat;
    logic [WR-1:0]   r3_mag;
    logic            r3_neg, r3_sat;
    t_qv             r4_p;

    logic [2*WD-1:0] n_full;
    logic [WR-1:0]   n_lim, n_mag;
    logic            n_clip;

    always_comb begin
        n_full = (2*WD)'(r2_p0) + ((2*WD)'(r2_p1) << 32) + ((2*WD)'(r2_p2) << 32)
               + ((2*WD)'(r2_p3) << 64);
        n_lim  = {{(WR-WD){1'b0}}, r3_neg, {(WD-1){~r3_neg}}};
        n_clip = r3_mag > n_lim;
        n_mag  = n_clip ? n_lim : r3_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ua  <= i_a.val[WD-1] ? WD'(-i_a.val) : i_a.val;
            r1_ub  <= i_b.val[WD-1] ? WD'(-i_b.val) : i_b.val;
            r1_neg <= i_a.val[WD-1] ^ i_b.val[WD-1];
            r1_sat <= i_a.sat | i_b.sat;

            r2_p0  <= 64'(r1_ua[31:0]) * 64'(r1_ub[31:0]);
            r2_p1  <= 48'(r1_ua[31:0]) * 48'(r1_ub[WD-1:32]);
            r2_p2  <= 48'(r1_ua[WD-1:32]) * 48'(r1_ub[31:0]);
            r2_p3  <= 32'(r1_ua[WD-1:32]) * 32'(r1_ub[WD-1:32]);
            r2_neg <= r1_neg;
            r2_sat <= r1_sat;

            r3_mag <= n_full[2*WD-1:FRAC];
            r3_neg <= r2_neg;
            r3_sat <= r2_sat;

            r4_p.sat <= r3_sat | n_clip;
            r4_p.val <= r3_neg ? -signed'(n_mag[WD-1:0]) : signed'(n_mag[WD-1:0]);
        end
    end

    assign o_p = r4_p;
endmodule

[sv/ldp_div.sv]
// Radix-2 restoring divider: (|p| << 28) / |z|, signed, clamped to 32 bits.
// Depends on ldp_pkg. Zero depth takes p << 12 instead.
module ldp_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [ldp_pkg::WQ-1:0] i_p,
    input  logic signed [ldp_pkg::WQ-1:0] i_z,
    output ldp_pkg::t_q32               o_q
);
    import ldp_pkg::*;

    localparam int NST = WQ;   // one quotient bit per stage

    typedef struct packed {
        logic [WQ-1:0] rem;
        logic [WQ-1:0] den;
        logic [WQ-1:0] quo;
        logic [3:0]    low;
        logic          neg;
        logic          ovf;
        logic          zero;
        t_q32          zq;
    } t_div_st;

    t_div_st r_st [NST+1];
    t_div_st n_st [NST+1];
    t_q32    r_out;

    logic [WQ-1:0] w_up, w_uz;
    logic [WQ:0]   w_t;
    logic [WQ:0]   w_diff;
    logic          w_ge;
    logic [WQ:0]   n_lim;
    logic          n_clip;
    logic [WQ-1:0] n_mag;

    always_comb begin
        w_up          = i_p[WQ-1] ? WQ'(-i_p) : i_p;
        w_uz          = i_z[WQ-1] ? WQ'(-i_z) : i_z;
        n_st[0].rem   = {4'd0, w_up[WQ-1:4]};
        n_st[0].den   = w_uz;
        n_st[0].quo   = '0;
        n_st[0].low   = w_up[3:0];
        n_st[0].neg   = i_p[WQ-1] ^ i_z[WQ-1];
        // quotient reaches 2^32 when |p| >= 16 |z|
        n_st[0].ovf   = {4'd0, w_up} >= {w_uz, 4'd0};
        n_st[0].zero  = (i_z == '0);
        n_st[0].zq    = f_clamp32(WS'(i_p) <<< 12);
        w_t           = '0;
        w_diff        = '0;
        w_ge          = 1'b0;
        // low dividend bits shift out of the top of low, zeros after them
        for (int k = 0; k < NST; k++) begin
            w_t             = {r_st[k].rem, r_st[k].low[3]};
            w_diff          = w_t - {1'b0, r_st[k].den};
            w_ge            = w_t >= {1'b0, r_st[k].den};
            n_st[k+1]       = r_st[k];
            n_st[k+1].rem   = w_ge ? w_diff[WQ-1:0] : w_t[WQ-1:0];
            n_st[k+1].quo   = {r_st[k].quo[WQ-2:0], w_ge};
            n_st[k+1].low   = {r_st[k].low[2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= NST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_comb begin
        n_lim  = {1'b0, r_st[NST].neg, {(WQ-1){~r_st[NST].neg}}};
        n_clip = r_st[NST].ovf || ({1'b0, r_st[NST].quo} > n_lim);
        n_mag  = n_clip ? n_lim[WQ-1:0] : r_st[NST].quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_st[NST].zero) begin
                r_out <= r_st[NST].zq;
            end else begin
                r_out.sat <= n_clip;
                r_out.val <= r_st[NST].neg ? -signed'(n_mag) : signed'(n_mag);
            end
        end
    end

    assign o_q = r_out;
endmodule

[sv/lens_distortion_projection_top.sv]
// Pinhole projection with Brown-Conrady distortion (k1 k2 k3, p1 p2), fixed point.
// Depends on ldp_pkg, ldp_div, ldp_mulq, ldp_delay.
//
//  port group      dir  beat contents (low bits first)
//  s_axis_*        in   tdata: point_x[31:0] point_y[63:32] point_z[95:64]
//  m_axis_*        out  tdata: pixel_u[31:0] pixel_v[63:32]; tuser: saturated
//  i_cfg_*         in   index 0..7 focal_x focal_y principal_point k1 k2 k3 p1 p2
//
// One beat in per cycle while no output beat waits. Each beat passes the divider,
// six multiply levels in series and four add/clamp registers.
// i_rst_n (synchronous) clears the valid chain and the coefficient registers.
// The whole pipeline holds while the output beat waits; s_axis_tready follows
// that hold, so nothing is dropped or repeated.
module lens_distortion_projection_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // point_x, point_y, point_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // pixel_u, pixel_v
    output logic        m_axis_tuser,   // saturated
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import ldp_pkg::*;

    localparam int LAT = 62;
    localparam int QW  = $bits(t_qv);

    logic                 w_en;
    logic [LAT:1]         r_vld;

    logic [WQ-1:0]        r_fx, r_fy;
    logic [63:0]          r_pp;
    logic signed [WQ-1:0] r_k1, r_k2, r_k3, r_p1, r_p2;

    t_qv  c_k1, c_k2, c_k3, c_p1, c_p2, c_fx, c_fy;
    t_q32 w_dx, w_dy;
    t_qv  w_x, w_y;

    t_qv  m_x2, m_y2, m_px, m_py, m_t5x, m_t5y;
    t_qv  w_x38, w_y38, w_x43, w_y43, w_x47, w_y47, w_x51, w_y51, w_x55, w_y55;
    t_qv  r_r2, r_x2d, r_y2d, r_sx, r_sy, w_r2d;
    t_qv  m_r4, m_k1r2, m_t4x, m_t4y, m_r6, m_k2r4, m_t1x, m_t1y;
    t_qv  m_k3r6, m_t2x, m_t2y, m_t3x, m_t3y;
    t_qv  w_t1x, w_t1y, w_t2x, w_t2y, w_t4x, w_t4y, w_t5x, w_t5y;
    t_qv  n_t5cx, n_t5cy;
    logic signed [WS-1:0] r_s1x, r_s2x, r_s1y, r_s2y;
    logic                 r_sax, r_say;
    t_qv  r_xd, r_yd, m_ux, m_uy;
    t_qv  n_r2, n_sx, n_sy, n_xd, n_yd;
    t_q32 n_u, n_v;
    logic [WQ-1:0]        r_u, r_v;
    logic                 r_sat;

    // pipeline advances unless the output beat is stuck
    assign w_en          = !r_vld[LAT] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT];
    assign m_axis_tdata  = {r_v, r_u};
    assign m_axis_tuser  = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-1:1], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= '0;
            r_fy <= '0;
            r_pp <= '0;
            r_k1 <= '0;
            r_k2 <= '0;
            r_k3 <= '0;
            r_p1 <= '0;
            r_p2 <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_FOCAL_X: r_fx <= i_cfg_data[WQ-1:0];
                REG_FOCAL_Y: r_fy <= i_cfg_data[WQ-1:0];
                REG_PP:      r_pp <= i_cfg_data;
                REG_K1:      r_k1 <= i_cfg_data[WQ-1:0];
                REG_K2:      r_k2 <= i_cfg_data[WQ-1:0];
                REG_K3:      r_k3 <= i_cfg_data[WQ-1:0];
                REG_P1:      r_p1 <= i_cfg_data[WQ-1:0];
                REG_P2:      r_p2 <= i_cfg_data[WQ-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        c_k1 = '{sat: 1'b0, val: WD'(r_k1)};
        c_k2 = '{sat: 1'b0, val: WD'(r_k2)};
        c_k3 = '{sat: 1'b0, val: WD'(r_k3)};
        c_p1 = '{sat: 1'b0, val: WD'(r_p1)};
        c_p2 = '{sat: 1'b0, val: WD'(r_p2)};
        c_fx = '{sat: 1'b0, val: signed'(WD'(r_fx))};
        c_fy = '{sat: 1'b0, val: signed'(WD'(r_fy))};
        w_x  = '{sat: w_dx.sat, val: WD'(w_dx.val)};
        w_y  = '{sat: w_dy.sat, val: WD'(w_dy.val)};
    end

    // normalization
    ldp_div u_div_x (.i_clk, .i_en(w_en), .i_p(signed'(s_axis_tdata[31:0])),
                     .i_z(signed'(s_axis_tdata[95:64])), .o_q(w_dx));
    ldp_div u_div_y (.i_clk, .i_en(w_en), .i_p(signed'(s_axis_tdata[63:32])),
                     .i_z(signed'(s_axis_tdata[95:64])), .o_q(w_dy));

    // normalized coordinates delayed to the multiply levels and the sum that use them
    ldp_delay #(.W(QW), .DEPTH(4)) u_dx38 (.i_clk, .i_en(w_en), .i_d(w_x),   .o_q(w_x38));
    ldp_delay #(.W(QW), .DEPTH(4)) u_dy38 (.i_clk, .i_en(w_en), .i_d(w_y),   .o_q(w_y38));
    ldp_delay #(.W(QW), .DEPTH(5)) u_dx43 (.i_clk, .i_en(w_en), .i_d(w_x38), .o_q(w_x43));
    ldp_delay #(.W(QW), .DEPTH(5)) u_dy43 (.i_clk, .i_en(w_en), .i_d(w_y38), .o_q(w_y43));
    ldp_delay #(.W(QW), .DEPTH(4)) u_dx47 (.i_clk, .i_en(w_en), .i_d(w_x43), .o_q(w_x47));
    ldp_delay #(.W(QW), .DEPTH(4)) u_dy47 (.i_clk, .i_en(w_en), .i_d(w_y43), .o_q(w_y47));
    ldp_delay #(.W(QW), .DEPTH(4)) u_dx51 (.i_clk, .i_en(w_en), .i_d(w_x47), .o_q(w_x51));
    ldp_delay #(.W(QW), .DEPTH(4)) u_dy51 (.i_clk, .i_en(w_en), .i_d(w_y47), .o_q(w_y51));
    ldp_delay #(.W(QW), .DEPTH(4)) u_dx55 (.i_clk, .i_en(w_en), .i_d(w_x51), .o_q(w_x55));
    ldp_delay #(.W(QW), .DEPTH(4)) u_dy55 (.i_clk, .i_en(w_en), .i_d(w_y51), .o_q(w_y55));

    // level 1: squares and the tangential cross inner products
    ldp_mulq u_m_x2 (.i_clk, .i_en(w_en), .i_a(w_x),  .i_b(w_x), .o_p(m_x2));
    ldp_mulq u_m_y2 (.i_clk, .i_en(w_en), .i_a(w_y),  .i_b(w_y), .o_p(m_y2));
    ldp_mulq u_m_px (.i_clk, .i_en(w_en), .i_a(c_p1), .i_b(w_x), .o_p(m_px));
    ldp_mulq u_m_py (.i_clk, .i_en(w_en), .i_a(c_p2), .i_b(w_y), .o_p(m_py));

    // r2, then r2 + 2a^2
    always_comb begin
        n_r2     = f_clamp48(WS'(m_x2.val) + WS'(m_y2.val));
        n_r2.sat = n_r2.sat | m_x2.sat | m_y2.sat;
        n_sx     = f_clamp48(WS'(r_r2.val) + (WS'(r_x2d.val) <<< 1));
        n_sx.sat = n_sx.sat | r_r2.sat | r_x2d.sat;
        n_sy     = f_clamp48(WS'(r_r2.val) + (WS'(r_y2d.val) <<< 1));
        n_sy.sat = n_sy.sat | r_r2.sat | r_y2d.sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2  <= n_r2;
            r_x2d <= m_x2;
            r_y2d <= m_y2;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
        end
    end

    // level 2: cross term outer products
    ldp_mulq u_m_t5x (.i_clk, .i_en(w_en), .i_a(m_px), .i_b(w_y38), .o_p(m_t5x));
    ldp_mulq u_m_t5y (.i_clk, .i_en(w_en), .i_a(m_py), .i_b(w_x38), .o_p(m_t5y));

    // level 3: r4, k1 r2, tangential radial terms
    ldp_mulq u_m_r4   (.i_clk, .i_en(w_en), .i_a(r_r2), .i_b(r_r2), .o_p(m_r4));
    ldp_mulq u_m_k1r2 (.i_clk, .i_en(w_en), .i_a(c_k1), .i_b(r_r2), .o_p(m_k1r2));
    ldp_mulq u_m_t4x  (.i_clk, .i_en(w_en), .i_a(c_p2), .i_b(r_sx), .o_p(m_t4x));
    ldp_mulq u_m_t4y  (.i_clk, .i_en(w_en), .i_a(c_p1), .i_b(r_sy), .o_p(m_t4y));
    ldp_delay #(.W(QW), .DEPTH(4)) u_dr2 (.i_clk, .i_en(w_en), .i_d(r_r2), .o_q(w_r2d));

    // level 4
    ldp_mulq u_m_r6   (.i_clk, .i_en(w_en), .i_a(w_r2d),  .i_b(m_r4),  .o_p(m_r6));
    ldp_mulq u_m_k2r4 (.i_clk, .i_en(w_en), .i_a(c_k2),   .i_b(m_r4),  .o_p(m_k2r4));
    ldp_mulq u_m_t1x  (.i_clk, .i_en(w_en), .i_a(m_k1r2), .i_b(w_x43), .o_p(m_t1x));
    ldp_mulq u_m_t1y  (.i_clk, .i_en(w_en), .i_a(m_k1r2), .i_b(w_y43), .o_p(m_t1y));

    // level 5
    ldp_mulq u_m_k3r6 (.i_clk, .i_en(w_en), .i_a(c_k3),   .i_b(m_r6),  .o_p(m_k3r6));
    ldp_mulq u_m_t2x  (.i_clk, .i_en(w_en), .i_a(m_k2r4), .i_b(w_x47), .o_p(m_t2x));
    ldp_mulq u_m_t2y  (.i_clk, .i_en(w_en), .i_a(m_k2r4), .i_b(w_y47), .o_p(m_t2y));

    // level 6
    ldp_mulq u_m_t3x (.i_clk, .i_en(w_en), .i_a(m_k3r6), .i_b(w_x51), .o_p(m_t3x));
    ldp_mulq u_m_t3y (.i_clk, .i_en(w_en), .i_a(m_k3r6), .i_b(w_y51), .o_p(m_t3y));

    // line the terms up for the sum
    ldp_delay #(.W(QW), .DEPTH(8))  u_d1x (.i_clk, .i_en(w_en), .i_d(m_t1x), .o_q(w_t1x));
    ldp_delay #(.W(QW), .DEPTH(8))  u_d1y (.i_clk, .i_en(w_en), .i_d(m_t1y), .o_q(w_t1y));
    ldp_delay #(.W(QW), .DEPTH(4))  u_d2x (.i_clk, .i_en(w_en), .i_d(m_t2x), .o_q(w_t2x));
    ldp_delay #(.W(QW), .DEPTH(4))  u_d2y (.i_clk, .i_en(w_en), .i_d(m_t2y), .o_q(w_t2y));
    ldp_delay #(.W(QW), .DEPTH(11)) u_d4x (.i_clk, .i_en(w_en), .i_d(m_t4x), .o_q(w_t4x));
    ldp_delay #(.W(QW), .DEPTH(11)) u_d4y (.i_clk, .i_en(w_en), .i_d(m_t4y), .o_q(w_t4y));
    ldp_delay #(.W(QW), .DEPTH(13)) u_d5x (.i_clk, .i_en(w_en), .i_d(m_t5x), .o_q(w_t5x));
    ldp_delay #(.W(QW), .DEPTH(13)) u_d5y (.i_clk, .i_en(w_en), .i_d(m_t5y), .o_q(w_t5y));

    always_comb begin
        n_t5cx = f_clamp48(WS'(w_t5x.val) <<< 1);
        n_t5cy = f_clamp48(WS'(w_t5y.val) <<< 1);
        n_xd     = f_clamp48(r_s1x + r_s2x);
        n_xd.sat = n_xd.sat | r_sax;
        n_yd     = f_clamp48(r_s1y + r_s2y);
        n_yd.sat = n_yd.sat | r_say;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1x <= WS'(w_x55.val) + WS'(w_t1x.val) + WS'(w_t2x.val);
            r_s2x <= WS'(m_t3x.val) + WS'(w_t4x.val) + WS'(n_t5cx.val);
            r_sax <= w_x55.sat | w_t1x.sat | w_t2x.sat | m_t3x.sat | w_t4x.sat
                   | w_t5x.sat | n_t5cx.sat;
            r_s1y <= WS'(w_y55.val) + WS'(w_t1y.val) + WS'(w_t2y.val);
            r_s2y <= WS'(m_t3y.val) + WS'(w_t4y.val) + WS'(n_t5cy.val);
            r_say <= w_y55.sat | w_t1y.sat | w_t2y.sat | m_t3y.sat | w_t4y.sat
                   | w_t5y.sat | n_t5cy.sat;
            r_xd  <= n_xd;
            r_yd  <= n_yd;
        end
    end

    // focal scaling
    ldp_mulq u_m_ux (.i_clk, .i_en(w_en), .i_a(r_xd), .i_b(c_fx), .o_p(m_ux));
    ldp_mulq u_m_uy (.i_clk, .i_en(w_en), .i_a(r_yd), .i_b(c_fy), .o_p(m_uy));

    always_comb begin
        n_u = f_clamp32(WS'(m_ux.val) + WS'(signed'({1'b0, r_pp[63:32]})));
        n_v = f_clamp32(WS'(m_uy.val) + WS'(signed'({1'b0, r_pp[31:0]})));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u   <= n_u.val;
            r_v   <= n_v.val;
            r_sat <= n_u.sat | n_v.sat | m_ux.sat | m_uy.sat;
        end
    end
endmodule

[sv/ldp_checker.sv]
// Port-level checks for the lens projection top, attached by bind.
// Depends on lens_distortion_projection_top_defines.svh.
`include "lens_distortion_projection_top_defines.svh"

module ldp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    logic w_out_free;

    assign w_out_free = !m_axis_tvalid || m_axis_tready;

    // reset empties the pipeline
    `LDP_ASSERT_ALL(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    // input side holds exactly when the output beat is stuck
    `LDP_ASSERT_RST(a_ready_link, i_clk, i_rst_n, s_axis_tready == w_out_free, "ready mismatch")

    `LDP_ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output beat changed")
endmodule

bind lens_distortion_projection_top ldp_checker u_ldp_checker (.*);

[verif/tb_lens_distortion_projection_top.sv]
// Self-checking bench for lens_distortion_projection_top: point beats in, pixel beats out.
// Depends on ldp_pkg and the block RTL; predicts each pixel from its own fixed-point model.
`timescale 1ns / 100ps

module tb_lens_distortion_projection_top;
    import ldp_pkg::*;

    localparam int  LATENCY   = 62;
    localparam longint LIM    = 64'sd1 <<< 47;
    localparam longint CYC_MAX = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    lens_distortion_projection_top dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct {
        logic [31:0] u;
        logic [31:0] v;
        logic        sat;
    } t_pixel;

    t_pixel pixel_q[$];

    // shadow of the coefficient registers
    logic [31:0] fx, fy;
    logic [63:0] pp;
    longint      k1, k2, k3, p1, p2;

    int  send_idle_pct, recv_stall_pct;
    int  n_err, n_pix, n_pts;
    longint cyc;

    // ---------------- predictor ----------------
    function automatic longint clamp_to(longint v, longint lo, longint hi, ref bit sat);
        if (v < lo) begin sat = 1; return lo; end
        if (v > hi) begin sat = 1; return hi; end
        return v;
    endfunction

    function automatic longint c48(longint v, ref bit sat);
        return clamp_to(v, -LIM, LIM - 1, sat);
    endfunction

    // Q.28 product, magnitude truncated, clamped to 48 bits
    function automatic longint qmul(longint a, longint b, ref bit sat);
        bit neg;
        logic [127:0] ua, ub, pr, r;
        longint lim;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 128'(-a) : 128'(a);
        ub = (b < 0) ? 128'(-b) : 128'(b);
        pr = ua * ub;
        r  = pr >> FRAC;
        lim = neg ? LIM : LIM - 1;
        if (r > 128'(lim)) begin sat = 1; r = 128'(lim); end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint normq(longint p, longint z, ref bit sat);
        bit neg;
        logic [63:0] q, lim;
        if (z == 0) return clamp_to(p * 4096, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1, sat);
        neg = (p < 0) != (z < 0);
        q = (((p < 0) ? 64'(-p) : 64'(p)) << FRAC) / ((z < 0) ? 64'(-z) : 64'(z));
        lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        if (q > lim) begin sat = 1; q = lim; end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint warp(longint a, longint b, longint a2, longint r2, longint r4,
                                    longint r6, longint pa, longint pb, ref bit sat);
        longint t1, t2, t3, t4, t5;
        t1 = qmul(qmul(k1, r2, sat), a, sat);
        t2 = qmul(qmul(k2, r4, sat), a, sat);
        t3 = qmul(qmul(k3, r6, sat), a, sat);
        t4 = qmul(pa, c48(r2 + 2 * a2, sat), sat);
        t5 = c48(2 * qmul(qmul(pb, a, sat), b, sat), sat);
        return c48(a + t1 + t2 + t3 + t4 + t5, sat);
    endfunction

    function automatic longint to_pix(longint d, logic [31:0] f, logic [31:0] c, ref bit sat);
        longint s;
        s = qmul(d, longint'({32'd0, f}), sat);
        return clamp_to(s + longint'({32'd0, c}), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1, sat);
    endfunction

    function automatic t_pixel project_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        t_pixel r;
        bit sat;
        longint x, y, x2, y2, r2, r4, r6, xd, yd;
        sat = 0;
        x  = normq(longint'($signed(px)), longint'($signed(pz)), sat);
        y  = normq(longint'($signed(py)), longint'($signed(pz)), sat);
        x2 = qmul(x, x, sat);
        y2 = qmul(y, y, sat);
        r2 = c48(x2 + y2, sat);
        r4 = qmul(r2, r2, sat);
        r6 = qmul(r2, r4, sat);
        xd = warp(x, y, x2, r2, r4, r6, p2, p1, sat);
        yd = warp(y, x, y2, r2, r4, r6, p1, p2, sat);
        r.u = 32'(to_pix(xd, fx, pp[63:32], sat));
        r.v = 32'(to_pix(yd, fy, pp[31:0], sat));
        r.sat = sat;
        return r;
    endfunction

    // ---------------- drivers ----------------
    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_FOCAL_X: fx = val[31:0];
            REG_FOCAL_Y: fy = val[31:0];
            REG_PP:      pp = val;
            REG_K1:      k1 = longint'($signed(val[31:0]));
            REG_K2:      k2 = longint'($signed(val[31:0]));
            REG_K3:      k3 = longint'($signed(val[31:0]));
            REG_P1:      p1 = longint'($signed(val[31:0]));
            default:     p2 = longint'($signed(val[31:0]));
        endcase
    endtask

    task automatic load_coeffs(logic [31:0] f_x, logic [31:0] f_y, logic [63:0] c,
                               logic [31:0] a1, logic [31:0] a2, logic [31:0] a3,
                               logic [31:0] t1, logic [31:0] t2);
        write_reg(REG_FOCAL_X, {32'd0, f_x});
        write_reg(REG_FOCAL_Y, {32'd0, f_y});
        write_reg(REG_PP, c);
        write_reg(REG_K1, {32'd0, a1});
        write_reg(REG_K2, {32'd0, a2});
        write_reg(REG_K3, {32'd0, a3});
        write_reg(REG_P1, {32'd0, t1});
        write_reg(REG_P2, {32'd0, t2});
    endtask

    // one point beat; valid stays high across back-to-back beats
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pz, py, px};
        pixel_q = {pixel_q, project_point(px, py, pz)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_pts++;
    endtask

    task automatic go_quiet();
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // ---------------- result check ----------------
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_pix++;
            if (pixel_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected pixel beat u=%h v=%h", m_axis_tdata[31:0],
                                          m_axis_tdata[63:32]);
            end else begin
                t_pixel e;
                e = pixel_q.pop_front();
                if (e.u !== m_axis_tdata[31:0] || e.v !== m_axis_tdata[63:32]
                        || e.sat !== m_axis_tuser) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("pixel mismatch: exp u=%h v=%h sat=%b got u=%h v=%h sat=%b",
                                 e.u, e.v, e.sat, m_axis_tdata[31:0], m_axis_tdata[63:32],
                                 m_axis_tuser);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (cyc > CYC_MAX) begin
            $display("lens_distortion_projection_top regression: fail");
            $finish;
        end
    end

    // ---------------- tests ----------------
    function automatic logic [31:0] rnd_point();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(8192)) - 4096);
            default: return 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    function automatic logic [31:0] rnd_depth();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return 32'($signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000);
            default: return 32'h0001_0000 + $urandom_range(32'h0040_0000);
        endcase
    endfunction

    function automatic logic [31:0] rnd_coeff(int wide);
        return wide ? $urandom : 32'($signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
    endfunction

    task automatic test_directed();
        logic [31:0] ext[6];
        ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0001_0000, 32'h1};
        load_coeffs(32'h01f4_0000, 32'h01f4_0000, {32'h0140_0000, 32'h00f0_0000},
                    32'hfc00_0000, 32'h0100_0000, 32'hff80_0000, 32'h0010_0000, 32'hfff0_0000);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0010_0000);
        send_point(32'h0, 32'h0, 32'h0);                          // zero depth, origin
        send_point(32'h0000_8000, 32'hffff_8000, 32'h0);          // zero depth, in range
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);          // zero depth, clamps
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h1);          // quotient clamps
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);  // ratio exactly one
        send_point(32'h0001_0000, 32'hffff_0000, 32'hffff_0000);  // negative depth
        for (int i = 0; i < 12; i++)
            send_point(ext[i % 6], ext[(i + 2) % 6], ext[(i + 3) % 6]);
        go_quiet();
        // extreme coefficients
        load_coeffs(32'hffff_ffff, 32'hffff_ffff, {64{1'b1}},
                    32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'h0000_1000, 32'hffff_f000, 32'h0001_0000);
        send_point(32'h0, 32'h0, 32'h0);
        go_quiet();
    endtask

    task automatic test_random_phase(int idle, int stall, int n, int wide);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        load_coeffs($urandom_range(32'h0400_0000), $urandom_range(32'h0400_0000),
                    {$urandom_range(32'h0400_0000), $urandom_range(32'h0400_0000)},
                    rnd_coeff(wide), rnd_coeff(wide), rnd_coeff(wide),
                    rnd_coeff(wide), rnd_coeff(wide));
        for (int i = 0; i < n; i++) begin
            send_point(rnd_point(), rnd_point(), rnd_depth());
            if (i == n / 2) go_quiet();   // hold off until the pipeline drains
        end
        go_quiet();
    endtask

    initial begin
        cyc = 0; n_err = 0; n_pix = 0; n_pts = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        fx = '0; fy = '0; pp = '0; k1 = 0; k2 = 0; k3 = 0; p1 = 0; p2 = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset values: all-zero coefficients
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        go_quiet();
        test_directed();
        test_random_phase(0, 0, 220, 0);
        test_random_phase(47, 0, 200, 1);
        test_random_phase(0, 47, 200, 0);
        test_random_phase(34, 34, 200, 1);
        $display("covered %0d points / %0d pixel beats over reset, directed extremes and",
                 n_pts, n_pix);
        $display("four random coefficient sets with sender gaps and receiver stalls");
        if (n_err == 0) begin
            $display("lens_distortion_projection_top regression: pass");
        end else begin
            $display("%0d mismatches", n_err);
            $display("lens_distortion_projection_top regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/ldp_pkg.sv
sv/ldp_delay.sv
sv/ldp_mulq.sv
sv/ldp_div.sv
sv/lens_distortion_projection_top.sv
sv/ldp_checker.sv
verif/tb_lens_distortion_projection_top.sv
